// ----- hw/rtl/lacp_pkg.sv -----
// Shared constants, types and the arcsine table for the lean angle block.
// No dependencies; every other file but lacp_ram takes names from here by scope.
package lacp_pkg;

    // Calibration and table geometry
    localparam int CAL_SAMPLES = 200;
    localparam int TABLE_BITS  = 10;
    localparam int TBL_LEN     = (1 << TABLE_BITS) + 1;
    localparam int TBL_AW      = $clog2(TBL_LEN);
    localparam int FILL_W      = $clog2(TBL_LEN + 1);
    localparam int TBL_W       = 21;
    localparam int FRAC_W      = 14;
    localparam int MAG_W       = 15;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int QX_W    = 16;
    localparam int RAW_W   = 16;
    localparam int LEAN_W  = 17;
    localparam int PEAK_W  = 16;
    localparam int TALLY_W = 8;
    localparam int SUM_W   = 23;

    // Rounded mean by reciprocal: exact for dividends below 2^23
    localparam int REC_W     = 32;
    localparam int DIV_SHIFT = 31;
    localparam longint unsigned DIV_RECIP =
        ((64'd1 << DIV_SHIFT) + longint'(CAL_SAMPLES) - 1) / longint'(CAL_SAMPLES);

    localparam logic signed [QX_W-1:0] Q_ONE = 16'sd16384;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Table generation
    localparam longint unsigned T_MAX  = 64'd1152000;
    localparam longint unsigned T_SPAN = 64'd2304000;
    localparam longint unsigned PI_Q40 = 64'd3454217652358;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_START  = 2'd1,
        CMD_CLEAR  = 2'd2
    } lacp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [RAW_W-1:0] raw;
    } lacp_item_t;

    typedef struct packed {
        logic [Q_CW-1:0] count;
        logic            not_empty;
    } lacp_qstat_t;

    typedef logic [TBL_W-1:0] asin_tbl_t [TBL_LEN];

    // Sine of t*pi/2304000 rad in Q30, nine truncated Taylor terms
    function automatic longint sine_q30(input longint unsigned t);
        longint unsigned theta;
        longint unsigned th2;
        longint unsigned term;
        longint          acc;
        theta = ((t * PI_Q40) / T_SPAN + 64'd512) >> 10;
        th2   = (theta * theta) >> 30;
        term  = theta;
        acc   = longint'(theta);
        // Each term is the previous one times theta^2 over (2k)(2k+1)
        term = ((term * th2) >> 30) / 64'd6;
        acc  = acc - longint'(term);
        term = ((term * th2) >> 30) / 64'd20;
        acc  = acc + longint'(term);
        term = ((term * th2) >> 30) / 64'd42;
        acc  = acc - longint'(term);
        term = ((term * th2) >> 30) / 64'd72;
        acc  = acc + longint'(term);
        term = ((term * th2) >> 30) / 64'd110;
        acc  = acc - longint'(term);
        term = ((term * th2) >> 30) / 64'd156;
        acc  = acc + longint'(term);
        term = ((term * th2) >> 30) / 64'd210;
        acc  = acc - longint'(term);
        term = ((term * th2) >> 30) / 64'd272;
        acc  = acc + longint'(term);
        return acc;
    endfunction

    // Largest angle whose sine does not exceed each table point
    function automatic asin_tbl_t build_asin_tbl();
        asin_tbl_t       tbl;
        longint          x;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        for (int i = 0; i < TBL_LEN; i++)
        begin
            x  = longint'(i) << (30 - TABLE_BITS);
            lo = 0;
            hi = T_MAX;
            while (lo < hi)
            begin
                mid = lo + (hi - lo + 1) / 2;
                if (sine_q30(mid) <= x)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 1;
                end
            end
            tbl[i] = TBL_W'(lo);
        end
        return tbl;
    endfunction

    localparam asin_tbl_t ASIN_TBL = build_asin_tbl();

endpackage

// ----- hw/rtl/lacp_if.sv -----
// Handshake channels for the lean angle block: item in, result out.
// Depends on lacp_pkg for field widths.
interface lacp_in_if;
    logic                           valid;
    logic                           ready;
    logic [lacp_pkg::CMD_W-1:0]     cmd;
    logic signed [lacp_pkg::QX_W-1:0] quat_x;

    modport source (output valid, output cmd, output quat_x, input ready);
    modport sink   (input valid, input cmd, input quat_x, output ready);
endinterface

interface lacp_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [lacp_pkg::RAW_W-1:0]  raw_angle;
    logic signed [lacp_pkg::LEAN_W-1:0] lean_angle;
    logic [lacp_pkg::PEAK_W-1:0]        peak_left;
    logic [lacp_pkg::PEAK_W-1:0]        peak_right;
    logic                               calibrating;
    logic [lacp_pkg::TALLY_W-1:0]       cal_count;
    logic signed [lacp_pkg::RAW_W-1:0]  offset_value;
    logic                               cal_done;

    modport source (output valid, output raw_angle, output lean_angle, output peak_left,
                    output peak_right, output calibrating, output cal_count,
                    output offset_value, output cal_done, input ready);
    modport sink   (input valid, input raw_angle, input lean_angle, input peak_left,
                    input peak_right, input calibrating, input cal_count,
                    input offset_value, input cal_done, output ready);
endinterface

// ----- hw/rtl/lacp_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module lacp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [WIDTH-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0]     raddr_a,
    input  logic [$clog2(DEPTH)-1:0]     raddr_b,
    output logic [WIDTH-1:0]             rdata_a,
    output logic [WIDTH-1:0]             rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- hw/rtl/lacp_front.sv -----
// Front end: table load after reset, input accept, clamp, table read and
// interpolation to the raw angle. Depends on lacp_pkg, lacp_if and lacp_ram.
module lacp_front (
    input  logic                   clk,
    input  logic                   rst_n,
    lacp_in_if.sink                item,
    input  lacp_pkg::lacp_qstat_t  qstat,
    output logic                   push,
    output lacp_pkg::lacp_item_t   push_data
);

    localparam int P_W = lacp_pkg::MAG_W + lacp_pkg::TABLE_BITS;
    localparam int V_W = lacp_pkg::TBL_W + 16;

    logic [lacp_pkg::FILL_W-1:0]  fill_cnt_reg;
    logic [lacp_pkg::FILL_W-1:0]  fill_cnt_next;
    logic                         fill_done;

    logic                         s1_valid_reg;
    logic [lacp_pkg::CMD_W-1:0]   s1_cmd_reg;
    logic                         s1_neg_reg;
    logic [lacp_pkg::FRAC_W-1:0]  s1_frac_reg;

    logic                         accept;
    logic [lacp_pkg::Q_CW-1:0]    in_flight;
    logic signed [lacp_pkg::QX_W-1:0] q_clamped;
    logic [lacp_pkg::MAG_W-1:0]   mag;
    logic [P_W-1:0]               p;
    logic [lacp_pkg::TBL_AW-1:0]  idx;
    logic [lacp_pkg::TBL_AW-1:0]  idx_hi;
    logic [lacp_pkg::TBL_W-1:0]   t0;
    logic [lacp_pkg::TBL_W-1:0]   t1;

    logic signed [lacp_pkg::TBL_W:0] diff;
    logic signed [V_W-1:0]        prod;
    logic signed [V_W-1:0]        v;
    logic [V_W-1:0]               v_pos;
    logic [V_W-1:0]               v_rnd;
    logic [lacp_pkg::RAW_W-1:0]   raw_mag;

    assign fill_done = (fill_cnt_reg == lacp_pkg::FILL_W'(lacp_pkg::TBL_LEN));
    assign fill_cnt_next = fill_done ? fill_cnt_reg : fill_cnt_reg + 1'b1;

    // Hold the input while the queue plus the word in flight could overflow
    assign in_flight  = qstat.count + lacp_pkg::Q_CW'(s1_valid_reg);
    assign item.ready = fill_done && (in_flight < lacp_pkg::Q_CW'(lacp_pkg::Q_DEPTH));
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        if (item.quat_x > lacp_pkg::Q_ONE)
        begin
            q_clamped = lacp_pkg::Q_ONE;
        end
        else if (item.quat_x < -lacp_pkg::Q_ONE)
        begin
            q_clamped = -lacp_pkg::Q_ONE;
        end
        else
        begin
            q_clamped = item.quat_x;
        end
    end

    assign mag = q_clamped[lacp_pkg::QX_W-1] ? lacp_pkg::MAG_W'(-q_clamped)
                                             : q_clamped[lacp_pkg::MAG_W-1:0];
    assign p   = P_W'(mag) << lacp_pkg::TABLE_BITS;
    assign idx = p[P_W-1:lacp_pkg::FRAC_W];
    // At the last point, read it twice so the slope term vanishes
    assign idx_hi = (idx == lacp_pkg::TBL_AW'(lacp_pkg::TBL_LEN - 1)) ? idx : idx + 1'b1;

    lacp_ram #(
        .WIDTH (lacp_pkg::TBL_W),
        .DEPTH (lacp_pkg::TBL_LEN)
    ) u_asin_ram (
        .clk     (clk),
        .we      (!fill_done),
        .waddr   (fill_cnt_reg[lacp_pkg::TBL_AW-1:0]),
        .wdata   (lacp_pkg::ASIN_TBL[fill_cnt_reg[lacp_pkg::TBL_AW-1:0]]),
        .raddr_a (idx),
        .raddr_b (idx_hi),
        .rdata_a (t0),
        .rdata_b (t1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            fill_cnt_reg <= fill_cnt_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= item.cmd;
            s1_neg_reg  <= q_clamped[lacp_pkg::QX_W-1];
            s1_frac_reg <= p[lacp_pkg::FRAC_W-1:0];
        end
    end

    // Linear interpolation, 20 low bits rounded off half up
    always_comb
    begin
        diff  = $signed({1'b0, t1}) - $signed({1'b0, t0});
        prod  = V_W'(diff) * V_W'($signed({1'b0, s1_frac_reg}));
        v     = $signed(V_W'({t0, lacp_pkg::FRAC_W'(0)})) + prod;
        v_pos = v[V_W-1] ? '0 : v;
        v_rnd = v_pos + (V_W'(1) << 19);
        raw_mag = v_rnd[20 +: lacp_pkg::RAW_W];
    end

    assign push          = s1_valid_reg;
    assign push_data.cmd = s1_cmd_reg;
    assign push_data.raw = s1_neg_reg ? -$signed(raw_mag) : $signed(raw_mag);

endmodule

// ----- hw/rtl/lacp_queue.sv -----
// Short FIFO between front and back; each side stalls on its own.
// Depends on lacp_pkg.
module lacp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lacp_pkg::lacp_item_t  push_data,
    input  logic                  pop,
    output lacp_pkg::lacp_item_t  head,
    output lacp_pkg::lacp_qstat_t qstat
);

    lacp_pkg::lacp_item_t       mem [lacp_pkg::Q_DEPTH];
    logic [lacp_pkg::Q_AW-1:0]  wr_ptr_reg;
    logic [lacp_pkg::Q_AW-1:0]  rd_ptr_reg;
    logic [lacp_pkg::Q_CW-1:0]  count_reg;
    logic [lacp_pkg::Q_AW-1:0]  wr_ptr_next;
    logic [lacp_pkg::Q_AW-1:0]  rd_ptr_next;
    logic [lacp_pkg::Q_CW-1:0]  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == lacp_pkg::Q_AW'(lacp_pkg::Q_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == lacp_pkg::Q_AW'(lacp_pkg::Q_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + lacp_pkg::Q_CW'(push) - lacp_pkg::Q_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head            = mem[rd_ptr_reg];
    assign qstat.count     = count_reg;
    assign qstat.not_empty = (count_reg != '0);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != lacp_pkg::Q_CW'(lacp_pkg::Q_DEPTH))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue read while empty");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a lone write");

endmodule

// ----- hw/rtl/lacp_back.sv -----
// Back end: calibration averaging, offset, peak hold and the result register.
// Depends on lacp_pkg and lacp_if.
module lacp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lacp_pkg::lacp_qstat_t qstat,
    input  lacp_pkg::lacp_item_t  head,
    output logic                  pop,
    lacp_out_if.source            result
);

    localparam int PROD_W = lacp_pkg::SUM_W + 1 + lacp_pkg::REC_W;

    // Architectural state
    logic                                cal_active_reg, cal_active_next;
    logic [lacp_pkg::TALLY_W-1:0]        tally_reg, tally_next;
    logic signed [lacp_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic signed [lacp_pkg::RAW_W-1:0]   offset_reg, offset_next;
    logic [lacp_pkg::PEAK_W-1:0]         left_reg, left_next;
    logic [lacp_pkg::PEAK_W-1:0]         right_reg, right_next;

    // Result register
    logic                                out_valid_reg, out_valid_next;
    logic signed [lacp_pkg::RAW_W-1:0]   raw_out_reg;
    logic signed [lacp_pkg::LEAN_W-1:0]  lean_out_reg, lean_next;
    logic                                done_reg, done_next;

    lacp_pkg::lacp_cmd_t                 cmd;
    logic signed [lacp_pkg::SUM_W:0]     sum_wide;
    logic signed [lacp_pkg::SUM_W-1:0]   sum_sat;
    logic [lacp_pkg::SUM_W:0]            sum_mag;
    logic [lacp_pkg::SUM_W:0]            dividend;
    logic [PROD_W-1:0]                   div_prod;
    logic [lacp_pkg::RAW_W-1:0]          quot;
    logic signed [lacp_pkg::RAW_W-1:0]   mean;
    logic [lacp_pkg::TALLY_W-1:0]        tally_inc;
    logic signed [lacp_pkg::LEAN_W-1:0]  corr;
    logic [lacp_pkg::LEAN_W-1:0]         corr_neg;

    assign pop = qstat.not_empty && (!out_valid_reg || result.ready);
    assign cmd = lacp_pkg::lacp_cmd_t'(head.cmd);

    // Saturating sum, then the rounded mean by a reciprocal multiply
    always_comb
    begin
        sum_wide = $signed({sum_reg[lacp_pkg::SUM_W-1], sum_reg})
                 + (lacp_pkg::SUM_W + 1)'(head.raw);
        if (sum_wide[lacp_pkg::SUM_W] != sum_wide[lacp_pkg::SUM_W-1])
        begin
            sum_sat = {sum_wide[lacp_pkg::SUM_W],
                       {(lacp_pkg::SUM_W-1){~sum_wide[lacp_pkg::SUM_W]}}};
        end
        else
        begin
            sum_sat = sum_wide[lacp_pkg::SUM_W-1:0];
        end
        sum_mag  = sum_sat[lacp_pkg::SUM_W-1]
                 ? (lacp_pkg::SUM_W + 1)'(-$signed({sum_sat[lacp_pkg::SUM_W-1], sum_sat}))
                 : {1'b0, sum_sat};
        dividend = sum_mag + (lacp_pkg::SUM_W + 1)'(lacp_pkg::CAL_SAMPLES / 2);
        div_prod = PROD_W'(dividend)
                 * PROD_W'(lacp_pkg::DIV_RECIP[lacp_pkg::REC_W-1:0]);
        quot     = div_prod[lacp_pkg::DIV_SHIFT +: lacp_pkg::RAW_W];
        mean     = sum_sat[lacp_pkg::SUM_W-1] ? -$signed(quot) : $signed(quot);
    end

    assign tally_inc = tally_reg + 1'b1;
    assign corr      = lacp_pkg::LEAN_W'(head.raw) - lacp_pkg::LEAN_W'(offset_reg);
    assign corr_neg  = lacp_pkg::LEAN_W'(-corr);

    always_comb
    begin
        cal_active_next = cal_active_reg;
        tally_next      = tally_reg;
        sum_next        = sum_reg;
        offset_next     = offset_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        done_next       = 1'b0;
        if (pop)
        begin
            unique case (cmd)
                lacp_pkg::CMD_START:
                begin
                    cal_active_next = 1'b1;
                    tally_next      = '0;
                    sum_next        = '0;
                end
                lacp_pkg::CMD_CLEAR:
                begin
                    left_next  = '0;
                    right_next = '0;
                end
                lacp_pkg::CMD_SAMPLE:
                begin
                    if (cal_active_reg)
                    begin
                        sum_next   = sum_sat;
                        tally_next = tally_inc;
                        if (tally_inc >= lacp_pkg::TALLY_W'(lacp_pkg::CAL_SAMPLES))
                        begin
                            offset_next     = mean;
                            cal_active_next = 1'b0;
                            done_next       = 1'b1;
                        end
                    end
                    else if (corr[lacp_pkg::LEAN_W-1])
                    begin
                        if (corr_neg > lacp_pkg::LEAN_W'(left_reg))
                        begin
                            left_next = corr_neg[lacp_pkg::PEAK_W-1:0];
                        end
                    end
                    else if (lacp_pkg::LEAN_W'(corr) > lacp_pkg::LEAN_W'(right_reg))
                    begin
                        right_next = corr[lacp_pkg::PEAK_W-1:0];
                    end
                end
                default:
                begin
                    // unused command: no state change
                end
            endcase
        end
        lean_next = lacp_pkg::LEAN_W'(head.raw) - lacp_pkg::LEAN_W'(offset_next);
    end

    assign out_valid_next = pop || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_active_reg <= 1'b0;
            tally_reg      <= '0;
            sum_reg        <= '0;
            offset_reg     <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cal_active_reg <= cal_active_next;
            tally_reg      <= tally_next;
            sum_reg        <= sum_next;
            offset_reg     <= offset_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // State registers double as the status part of the result
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            raw_out_reg  <= head.raw;
            lean_out_reg <= lean_next;
            done_reg     <= done_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.raw_angle    = raw_out_reg;
    assign result.lean_angle   = lean_out_reg;
    assign result.peak_left    = left_reg;
    assign result.peak_right   = right_reg;
    assign result.calibrating  = cal_active_reg;
    assign result.cal_count    = tally_reg;
    assign result.offset_value = offset_reg;
    assign result.cal_done     = done_reg;

    a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tally_reg <= lacp_pkg::TALLY_W'(lacp_pkg::CAL_SAMPLES))
        else $error("calibration count beyond target");

    a_state_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !pop |=> $stable(offset_reg) && $stable(left_reg) && $stable(right_reg)
                 && $stable(cal_active_reg))
        else $error("state moved without a transaction");

    a_done_ends_cal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> !cal_active_reg)
        else $error("calibration still active on its completing result");

endmodule

// ----- hw/rtl/lean_angle_calibrate_and_peak.sv -----
// Top level of the lean angle block: front end, queue and back end.
// Depends on lacp_pkg, lacp_if, lacp_ram, lacp_front, lacp_queue, lacp_back.
//
//   channel  modport  payload                                     role
//   item     sink     cmd, quat_x                                 command and Q1.14 sample
//   result   source   raw_angle, lean_angle, peak_left/right,     one per transaction
//                     calibrating, cal_count, offset_value, cal_done
//
// One transaction per cycle sustained while result.ready holds; a result is offered once
// its input has passed the table read on the accepting edge, interpolation into the
// queue and the result register.
// After reset the arcsine RAM is loaded one entry a cycle, all TBL_LEN entries
// (1025 at the default table size), with item.ready low throughout.
// A four-entry queue absorbs a stalled result side; item.ready drops when the
// queue and the word in flight would fill it.
module lean_angle_calibrate_and_peak (
    input  logic        clk,
    input  logic        rst_n,
    lacp_in_if.sink     item,
    lacp_out_if.source  result
);

    logic                  push;
    logic                  pop;
    lacp_pkg::lacp_item_t  push_data;
    lacp_pkg::lacp_item_t  head;
    lacp_pkg::lacp_qstat_t qstat;

    lacp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    lacp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    lacp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .qstat  (qstat),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule
